@@ hdl/idmba_pkg.sv @@
// Shared opcodes, status codes and pipeline control types for the integer ALU core.
package idmba_pkg;

	localparam logic [4:0] OP_DIV32    = 5'd0;
	localparam logic [4:0] OP_REM32    = 5'd1;
	localparam logic [4:0] OP_DIVU32   = 5'd2;
	localparam logic [4:0] OP_REMU32   = 5'd3;
	localparam logic [4:0] OP_SHL64    = 5'd4;
	localparam logic [4:0] OP_SHR64    = 5'd5;
	localparam logic [4:0] OP_SAR64    = 5'd6;
	localparam logic [4:0] OP_DIV64    = 5'd7;
	localparam logic [4:0] OP_REM64    = 5'd8;
	localparam logic [4:0] OP_DIVU64   = 5'd9;
	localparam logic [4:0] OP_REMU64   = 5'd10;
	localparam logic [4:0] OP_MULUH    = 5'd11;
	localparam logic [4:0] OP_MULSH    = 5'd12;
	localparam logic [4:0] OP_CLZ32    = 5'd13;
	localparam logic [4:0] OP_CTZ32    = 5'd14;
	localparam logic [4:0] OP_CLZ64    = 5'd15;
	localparam logic [4:0] OP_CTZ64    = 5'd16;
	localparam logic [4:0] OP_CLRSB32  = 5'd17;
	localparam logic [4:0] OP_CLRSB64  = 5'd18;
	localparam logic [4:0] OP_CTPOP32  = 5'd19;
	localparam logic [4:0] OP_CTPOP64  = 5'd20;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_DIVZ   = 2'd1;
	localparam logic [1:0] ST_OVF    = 2'd2;
	localparam logic [1:0] ST_SHIFT  = 2'd3;

	localparam int DIV_STAGES = 64;

	// Control that travels beside the divider array.
	typedef struct packed {
		logic [63:0] res;
		logic [1:0]  st;
		logic        use_div;
		logic        rem_sel;
		logic        neg;
		logic        is32;
		logic        is_mul;
		logic        is_smul;
	} ctrl_t;

endpackage

@@ hdl/integer_div_mulh_bitcount_alu_core.sv @@
// Pipelined integer ALU: divide/remainder, shifts, high product halves and bit counts.
// Usage: drive opcode, operand_a and operand_b with start high for one cycle per
// transaction; the transaction is taken at the rising edge where start is high and
// busy is low. busy is never raised, so a new transaction may enter every cycle.
// Each transaction gives one result: result and status are shown for exactly one
// cycle with done high, once the transaction has passed through the whole pipeline.
// Results leave in the order the transactions entered. Throughput is one per cycle.
// The latency is set by the divider: an array of 64 restoring stages, one quotient
// bit per stage, preceded by an input register and an operand conditioning stage
// and followed by the sign fixup and output register. Multiply and bit-count work
// finishes early and rides a delay line beside the divider.
// The receiver cannot stall; done must be taken when it is shown.
// Reset (arst_n low) drops every transaction in flight; the output payload is not
// cleared but done stays low until new transactions reach the end.
module integer_div_mulh_bitcount_alu_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [4:0]  opcode,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	output logic        done,
	output logic [63:0] result,
	output logic [1:0]  status
);

	localparam int NS = idmba_pkg::DIV_STAGES;

	function automatic logic [6:0] lz64(input logic [63:0] v);
		logic [6:0] n;
		n = 7'd64;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) n = 7'(63 - i);
		end
		return n;
	endfunction

	function automatic logic [6:0] tz64(input logic [63:0] v);
		logic [6:0] n;
		n = 7'd64;
		for (int i = 63; i >= 0; i--) begin
			if (v[i]) n = 7'(i);
		end
		return n;
	endfunction

	function automatic logic [6:0] pop64(input logic [63:0] v);
		logic [6:0] n;
		n = 7'd0;
		for (int i = 0; i < 64; i++) begin
			n = n + {6'd0, v[i]};
		end
		return n;
	endfunction

	// input register
	logic        v_s1;
	logic [4:0]  op_s1;
	logic [63:0] a_s1, b_s1;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		op_s1 <= opcode;
		a_s1  <= operand_a;
		b_s1  <= operand_b;
	end

	// decode and side results
	idmba_pkg::ctrl_t ctl_d;
	logic [63:0] ma_d, mb_d;
	logic [63:0] a32, b32, x32, x64;
	logic        is_sdiv, is_udiv, is32_d, rem_d, na, nb, bz, ovf;
	logic [63:0] aw, bw, mask_w;
	logic [1:0]  sh_st;

	always_comb begin
		a32 = {32'd0, a_s1[31:0]};
		b32 = {32'd0, b_s1[31:0]};
		x32 = a_s1[31] ? {32'd0, ~a_s1[31:0]} : a32;
		x64 = a_s1[63] ? ~a_s1 : a_s1;
		is_sdiv = (op_s1 == idmba_pkg::OP_DIV32) || (op_s1 == idmba_pkg::OP_REM32) ||
			(op_s1 == idmba_pkg::OP_DIV64) || (op_s1 == idmba_pkg::OP_REM64);
		is_udiv = (op_s1 == idmba_pkg::OP_DIVU32) || (op_s1 == idmba_pkg::OP_REMU32) ||
			(op_s1 == idmba_pkg::OP_DIVU64) || (op_s1 == idmba_pkg::OP_REMU64);
		is32_d = (op_s1 == idmba_pkg::OP_DIV32) || (op_s1 == idmba_pkg::OP_REM32) ||
			(op_s1 == idmba_pkg::OP_DIVU32) || (op_s1 == idmba_pkg::OP_REMU32);
		rem_d = (op_s1 == idmba_pkg::OP_REM32) || (op_s1 == idmba_pkg::OP_REMU32) ||
			(op_s1 == idmba_pkg::OP_REM64) || (op_s1 == idmba_pkg::OP_REMU64);
		aw = is32_d ? a32 : a_s1;
		bw = is32_d ? b32 : b_s1;
		mask_w = is32_d ? 64'h0000_0000_FFFF_FFFF : '1;
		na = is_sdiv && (is32_d ? a_s1[31] : a_s1[63]);
		nb = is_sdiv && (is32_d ? b_s1[31] : b_s1[63]);
		bz = (bw == 64'd0);
		ovf = is_sdiv && (bw == mask_w) &&
			(is32_d ? (a_s1[31:0] == 32'h8000_0000) : (a_s1 == 64'h8000_0000_0000_0000));
		ma_d = na ? ((64'd0 - aw) & mask_w) : aw;
		mb_d = nb ? ((64'd0 - bw) & mask_w) : bw;
		sh_st = (b_s1[63:6] != 58'd0) ? idmba_pkg::ST_SHIFT : idmba_pkg::ST_OK;

		ctl_d = '0;
		ctl_d.is32 = is32_d;
		ctl_d.rem_sel = rem_d;
		ctl_d.neg = rem_d ? na : (na ^ nb);
		if (is_sdiv || is_udiv) begin
			if (bz) begin
				ctl_d.res = rem_d ? aw : mask_w;
				ctl_d.st = idmba_pkg::ST_DIVZ;
			end else if (ovf) begin
				ctl_d.res = rem_d ? 64'd0 : aw;
				ctl_d.st = idmba_pkg::ST_OVF;
			end else begin
				ctl_d.use_div = 1'b1;
			end
		end
		case (op_s1)
			idmba_pkg::OP_SHL64: begin
				ctl_d.res = a_s1 << b_s1[5:0];
				ctl_d.st = sh_st;
			end
			idmba_pkg::OP_SHR64: begin
				ctl_d.res = a_s1 >> b_s1[5:0];
				ctl_d.st = sh_st;
			end
			idmba_pkg::OP_SAR64: begin
				ctl_d.res = $unsigned($signed(a_s1) >>> b_s1[5:0]);
				ctl_d.st = sh_st;
			end
			idmba_pkg::OP_MULUH: ctl_d.is_mul = 1'b1;
			idmba_pkg::OP_MULSH: begin
				ctl_d.is_mul = 1'b1;
				ctl_d.is_smul = 1'b1;
			end
			idmba_pkg::OP_CLZ32: ctl_d.res = (a32 == 64'd0) ? b32 :
				{57'd0, lz64({a_s1[31:0], 32'hFFFF_FFFF})};
			idmba_pkg::OP_CTZ32: ctl_d.res = (a32 == 64'd0) ? b32 :
				{57'd0, tz64({32'hFFFF_FFFF, a_s1[31:0]})};
			idmba_pkg::OP_CLZ64: ctl_d.res = (a_s1 == 64'd0) ? b_s1 : {57'd0, lz64(a_s1)};
			idmba_pkg::OP_CTZ64: ctl_d.res = (a_s1 == 64'd0) ? b_s1 : {57'd0, tz64(a_s1)};
			idmba_pkg::OP_CLRSB32:
				ctl_d.res = {57'd0, lz64({x32[31:0], 32'hFFFF_FFFF}) - 7'd1};
			idmba_pkg::OP_CLRSB64: ctl_d.res = {57'd0, lz64(x64) - 7'd1};
			idmba_pkg::OP_CTPOP32: ctl_d.res = {57'd0, pop64(a32)};
			idmba_pkg::OP_CTPOP64: ctl_d.res = {57'd0, pop64(a_s1)};
			default: ;
		endcase
	end

	// multiplier: partial products, then sum, then signed correction
	logic [63:0] mul_ll_s2, mul_lh_s2, mul_hl_s2, mul_hh_s2, mul_corr_s2;
	logic [63:0] mul_hi_s3, mul_corr_s3;

	always_ff @(posedge clk) begin
		mul_ll_s2   <= {32'd0, a_s1[31:0]} * {32'd0, b_s1[31:0]};
		mul_lh_s2   <= {32'd0, a_s1[31:0]} * {32'd0, b_s1[63:32]};
		mul_hl_s2   <= {32'd0, a_s1[63:32]} * {32'd0, b_s1[31:0]};
		mul_hh_s2   <= {32'd0, a_s1[63:32]} * {32'd0, b_s1[63:32]};
		mul_corr_s2 <= (a_s1[63] ? b_s1 : 64'd0) + (b_s1[63] ? a_s1 : 64'd0);
	end

	logic [127:0] mul_sum;
	assign mul_sum = {mul_hh_s2, mul_ll_s2} + {32'd0, mul_lh_s2, 32'd0} +
		{32'd0, mul_hl_s2, 32'd0};

	always_ff @(posedge clk) begin
		mul_hi_s3   <= mul_sum[127:64];
		mul_corr_s3 <= mul_corr_s2;
	end

	// divider array and control delay line; index 0 is the conditioning stage
	logic                 vld_sn [0:NS];
	idmba_pkg::ctrl_t     ctl_sn [0:NS];
	logic [63:0]          rem_sn [0:NS];
	logic [63:0]          quo_sn [0:NS];
	logic [63:0]          dvs_sn [0:NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sn[0] <= 1'b0;
		else vld_sn[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		ctl_sn[0] <= ctl_d;
		rem_sn[0] <= 64'd0;
		quo_sn[0] <= ma_d;
		dvs_sn[0] <= mb_d;
	end

	for (genvar k = 0; k < NS; k++) begin : g_div
		logic [64:0] trial;
		logic [64:0] diff;
		logic        take;
		idmba_pkg::ctrl_t ctl_nx;

		assign trial = {rem_sn[k], quo_sn[k][63]};
		assign diff  = trial - {1'b0, dvs_sn[k]};
		assign take  = !diff[64];

		always_comb begin
			ctl_nx = ctl_sn[k];
			// fold the signed correction into the side result after the product sum
			if (k == 1 && ctl_sn[k].is_mul) begin
				ctl_nx.res = ctl_sn[k].is_smul ? (mul_hi_s3 - mul_corr_s3) : mul_hi_s3;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sn[k+1] <= 1'b0;
			else vld_sn[k+1] <= vld_sn[k];
		end

		always_ff @(posedge clk) begin
			ctl_sn[k+1] <= ctl_nx;
			rem_sn[k+1] <= take ? diff[63:0] : trial[63:0];
			quo_sn[k+1] <= {quo_sn[k][62:0], take};
			dvs_sn[k+1] <= dvs_sn[k];
		end
	end

	// sign fixup and output register
	logic [63:0] dv_raw, dv_fix;

	always_comb begin
		dv_raw = ctl_sn[NS].rem_sel ? rem_sn[NS] : quo_sn[NS];
		dv_fix = ctl_sn[NS].neg ? (64'd0 - dv_raw) : dv_raw;
		if (ctl_sn[NS].is32) dv_fix = {32'd0, dv_fix[31:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_sn[NS];
	end

	always_ff @(posedge clk) begin
		result <= ctl_sn[NS].use_div ? dv_fix : ctl_sn[NS].res;
		status <= ctl_sn[NS].st;
	end

`ifndef SYNTH
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, NS + 3))
		else $error("result strobe without a matching transaction");

	a_ovf_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == idmba_pkg::ST_OVF) |->
		(result == 64'd0 || result == 64'h8000_0000_0000_0000 ||
		result == 64'h0000_0000_8000_0000))
		else $error("overflow status with unexpected result");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !busy)
		else $error("core refused a transaction");
`endif

endmodule
